// ----- src/extent_block_allocator_assert.svh -----
// assertion macros for the extent allocator
`ifndef EXTENT_BLOCK_ALLOCATOR_ASSERT_SVH
`define EXTENT_BLOCK_ALLOCATOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define EBA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define EBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/eba_pkg.sv -----
// ----------------------------------------------------------------------------
// eba_pkg
// types, codes and defaults shared by the extent allocator
// ----------------------------------------------------------------------------
package eba_pkg;

  localparam int unsigned NumGroupsDef  = 256;
  localparam int unsigned MaxExtentsDef = 256;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_USED  = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_BAD        = 2'd3;

  localparam logic REG_BPG    = 1'b0;
  localparam logic REG_GCOUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] group;
    logic [15:0] local_offset;
    logic [31:0] blocks;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] extent_offset;
    logic [15:0] extent_count;
    logic [23:0] total_used;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GRD,     // read group metadata
    S_GCHK,    // check group
    S_ERD,     // issue extent read
    S_EWAIT,   // extent data returns
    S_LRD,     // read last entry
    S_LWAIT,
    S_FIN,     // write back and respond
    S_OUT
  } state_t;

endpackage

// ----- src/eba_if.sv -----
// ----------------------------------------------------------------------------
// eba_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface eba_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/eba_ext_mem.sv -----
// ----------------------------------------------------------------------------
// eba_ext_mem
// extent table memory, offset and length per entry, one read and one write port
// ----------------------------------------------------------------------------
module eba_ext_mem #(
  parameter int unsigned AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/eba_grp_mem.sv -----
// ----------------------------------------------------------------------------
// eba_grp_mem
// per group metadata memory: extent count and used block count
// ----------------------------------------------------------------------------
module eba_grp_mem #(
  parameter int unsigned GW = 8,
  parameter int unsigned DW = 22
) (
  input  logic          clk,
  input  logic          we,
  input  logic [GW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [GW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**GW];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/extent_block_allocator.sv -----
// ----------------------------------------------------------------------------
// extent_block_allocator
// extent based free space allocator over block groups
// ----------------------------------------------------------------------------
// channel   | dir | transfer when   | payload
// in_ch     | in  | valid && ready  | mode, group, local_offset, blocks
// out_ch    | out | valid && ready  | status, extent_offset, extent_count, total_used
// cfg       | in  | cfg_we          | cfg_index, cfg_data
// one item at a time; a load or used-count update passes group read, check
// and write back before its result is offered
// an allocation reads the group metadata, repeating the read stage for each
// subtraction that reduces the start group modulo the group count, then checks
// one group per step, scans the served group with an issue and a wait state per
// extent and finishes with the last entry read and the write back: the single
// read port of the extent memory sets the scan pace
// after reset the block clears the group metadata memory, one group per cycle, and takes no item meanwhile.
// a result waits in the output register; the next item is taken once it leaves.
// ----------------------------------------------------------------------------
`include "extent_block_allocator_assert.svh"

module extent_block_allocator #(
  parameter int unsigned NUM_GROUPS  = eba_pkg::NumGroupsDef,
  parameter int unsigned MAX_EXTENTS = eba_pkg::MaxExtentsDef
) (
  input  logic        clk,
  input  logic        rst,
  eba_if.sink         in_ch,
  eba_if.source       out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned EW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned AW = GW + EW;
  localparam int unsigned MW = CW + 13;

  eba_pkg::state_t state, state_next;

  // configuration
  logic [12:0] blocks_per_group, group_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_group <= 13'd4096;
      group_count      <= 13'd1;
    end else if (cfg_we) begin
      if (cfg_index == eba_pkg::REG_BPG) blocks_per_group <= cfg_data;
      else group_count <= cfg_data;
    end
  end

  // clearing pass over group metadata
  logic          clearing;
  logic [GW:0]   clr_ptr;

  // item registers
  eba_pkg::req_t req;
  eba_pkg::rsp_t rsp;
  logic [23:0]   volume_used;
  logic [23:0]   volume_next;
  logic [12:0]   gc_eff;
  logic [GW-1:0] grp;
  logic [12:0]   visited;
  logic [CW-1:0] cnt;
  logic [12:0]   used;
  logic [EW-1:0] idx, best, hit;
  logic [15:0]   best_len, best_off;
  logic [15:0]   hit_off, hit_len;
  logic          split, found;
  logic [1:0]    status;

  // memories
  logic          gm_we;
  logic [GW-1:0] gm_waddr, gm_raddr;
  logic [MW-1:0] gm_wdata, gm_rdata;
  logic          em_we;
  logic [AW-1:0] em_waddr, em_raddr;
  logic [31:0]   em_wdata, em_rdata;

  eba_grp_mem #(.GW(GW), .DW(MW)) u_grp (
    .clk, .we(gm_we), .waddr(gm_waddr), .wdata(gm_wdata),
    .raddr(gm_raddr), .rdata(gm_rdata)
  );
  eba_ext_mem #(.AW(AW)) u_ext (
    .clk, .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
    .raddr(em_raddr), .rdata(em_rdata)
  );

  wire [CW-1:0] gm_cnt  = gm_rdata[MW-1:13];
  wire [12:0]   gm_used = gm_rdata[12:0];
  wire [15:0]   e_off   = em_rdata[31:16];
  wire [15:0]   e_len   = em_rdata[15:0];
  wire          accept  = in_ch.valid && in_ch.ready;
  wire          grp_ok  = 13'(req.group) < 13'(NUM_GROUPS);
  // requested, loaded or used block count fits in 16 bits
  wire          blk_fits = req.blocks[31:16] == 16'd0;
  wire [12:0]   sat_used = (req.blocks[15:13] != 3'd0) ? 13'h1FFF : req.blocks[12:0];
  wire [EW-1:0] last    = EW'(cnt - CW'(1));
  wire [12:0]   gc_next = (group_count < 13'(NUM_GROUPS)) ? group_count : 13'(NUM_GROUPS);
  wire [15:0]   take_cnt = found ? req.blocks[15:0] : best_len;
  // start group modulo the effective count, worked by repeated subtraction
  logic [12:0]  start_rem;

  assign in_ch.ready  = (state == eba_pkg::S_IDLE) && !clearing;
  assign out_ch.valid = (state == eba_pkg::S_OUT);
  assign out_ch.data  = rsp;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      eba_pkg::S_IDLE:  if (accept) state_next = eba_pkg::S_GRD;
      eba_pkg::S_GRD: begin
        if (req.mode == eba_pkg::MODE_ALLOC && start_rem >= gc_eff && gc_eff != 13'd0)
          state_next = eba_pkg::S_GRD;
        else state_next = eba_pkg::S_GCHK;
      end
      eba_pkg::S_GCHK: begin
        priority if (req.mode != eba_pkg::MODE_ALLOC) state_next = eba_pkg::S_FIN;
        else if (req.blocks == 32'd0 || visited >= gc_eff) state_next = eba_pkg::S_FIN;
        else if (gm_used >= blocks_per_group || gm_cnt == CW'(0))
          state_next = eba_pkg::S_GCHK;
        else state_next = eba_pkg::S_ERD;
      end
      eba_pkg::S_ERD:   state_next = eba_pkg::S_EWAIT;
      eba_pkg::S_EWAIT: begin
        priority if (blk_fits && e_len >= req.blocks[15:0])
          state_next = eba_pkg::S_LRD;
        else if (CW'(idx) + CW'(1) >= cnt) state_next = eba_pkg::S_LRD;
        else state_next = eba_pkg::S_ERD;
      end
      eba_pkg::S_LRD:   state_next = eba_pkg::S_LWAIT;
      eba_pkg::S_LWAIT: state_next = eba_pkg::S_FIN;
      eba_pkg::S_FIN:   state_next = eba_pkg::S_OUT;
      eba_pkg::S_OUT:   if (out_ch.ready) state_next = eba_pkg::S_IDLE;
      default:          state_next = eba_pkg::S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    gm_we = 1'b0; gm_waddr = grp; gm_wdata = {cnt, used};
    gm_raddr = grp;
    em_we = 1'b0; em_waddr = {grp, idx}; em_wdata = 32'd0;
    em_raddr = {grp, idx};
    if (clearing) begin
      gm_we = 1'b1; gm_waddr = clr_ptr[GW-1:0]; gm_wdata = '0;
    end
    unique case (state)
      eba_pkg::S_GRD:  gm_raddr = (req.mode == eba_pkg::MODE_ALLOC) ? GW'(start_rem)
                                                                    : GW'(req.group);
      eba_pkg::S_GCHK: gm_raddr = grp + GW'(1) >= GW'(gc_eff) && gc_eff <= 13'(2**GW - 1)
                                  && 13'(grp) + 13'd1 >= gc_eff ? '0 : grp + GW'(1);
      // last entry held on the read port until write back
      eba_pkg::S_LRD, eba_pkg::S_LWAIT: em_raddr = {grp, last};
      eba_pkg::S_FIN: begin
        if (!clearing) begin
          if (req.mode == eba_pkg::MODE_LOAD && status == eba_pkg::ST_OK) begin
            gm_we = 1'b1; gm_wdata = {cnt + CW'(1), used};
            em_we = 1'b1; em_waddr = {grp, EW'(cnt)};
            em_wdata = {req.local_offset, req.blocks[15:0]};
          end else if (req.mode == eba_pkg::MODE_USED && status == eba_pkg::ST_OK) begin
            gm_we = 1'b1; gm_wdata = {cnt, sat_used};
          end else if (req.mode == eba_pkg::MODE_ALLOC && status == eba_pkg::ST_OK) begin
            gm_we = 1'b1;
            gm_wdata = {split ? cnt : cnt - CW'(1), used + take_cnt[12:0]};
            em_we = 1'b1; em_waddr = {grp, hit};
            em_wdata = split ? {hit_off + req.blocks[15:0], hit_len - req.blocks[15:0]}
                             : em_rdata;
          end
        end
      end
      default: ;
    endcase
  end

  // volume total after the current item
  always_comb begin
    volume_next = volume_used;
    if (status == eba_pkg::ST_OK) begin
      if (req.mode == eba_pkg::MODE_USED)
        volume_next = volume_used + 24'(sat_used) - 24'(used);
      else if (req.mode == eba_pkg::MODE_ALLOC)
        volume_next = volume_used + 24'(take_cnt);
    end
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eba_pkg::S_IDLE;
      clearing <= 1'b1;
      clr_ptr <= '0;
      volume_used <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_ptr <= clr_ptr + 1'b1;
        if (clr_ptr == (GW+1)'(NUM_GROUPS - 1)) clearing <= 1'b0;
      end
      if (state == eba_pkg::S_FIN) volume_used <= volume_next;
    end
    unique case (state)
      eba_pkg::S_IDLE: begin
        req <= in_ch.data;
        start_rem <= {1'b0, in_ch.data.group};
        gc_eff <= gc_next;
        visited <= '0;
      end
      eba_pkg::S_GRD: begin
        if (req.mode == eba_pkg::MODE_ALLOC && start_rem >= gc_eff && gc_eff != 13'd0)
          start_rem <= start_rem - gc_eff;
        grp <= (req.mode == eba_pkg::MODE_ALLOC) ?
               ((start_rem >= gc_eff) ? '0 : GW'(start_rem)) : GW'(req.group);
      end
      eba_pkg::S_GCHK: begin
        cnt <= gm_cnt; used <= gm_used;
        idx <= '0; best <= '0; best_len <= '0; best_off <= '0;
        found <= 1'b0; split <= 1'b0;
        if (req.mode == eba_pkg::MODE_LOAD) begin
          status <= (!grp_ok || !blk_fits) ? eba_pkg::ST_BAD :
                    (gm_cnt >= CW'(MAX_EXTENTS)) ? eba_pkg::ST_TABLE_FULL : eba_pkg::ST_OK;
        end else if (req.mode == eba_pkg::MODE_USED) begin
          status <= (!grp_ok || !blk_fits) ? eba_pkg::ST_BAD : eba_pkg::ST_OK;
        end else if (req.mode == eba_pkg::MODE_ALLOC) begin
          status <= (req.blocks == 32'd0) ? eba_pkg::ST_BAD :
                    (visited >= gc_eff) ? eba_pkg::ST_FULL : eba_pkg::ST_OK;
          if (state_next == eba_pkg::S_GCHK) begin
            visited <= visited + 13'd1;
            grp <= (13'(grp) + 13'd1 >= gc_eff) ? '0 : grp + GW'(1);
          end
        end else begin
          status <= eba_pkg::ST_BAD;
        end
      end
      eba_pkg::S_EWAIT: begin
        if (e_len > req.blocks[15:0] && blk_fits) begin
          hit <= idx; hit_off <= e_off; hit_len <= e_len; found <= 1'b1; split <= 1'b1;
        end else if (blk_fits && e_len == req.blocks[15:0]) begin
          hit <= idx; hit_off <= e_off; hit_len <= e_len; found <= 1'b1;
        end else if (CW'(idx) + CW'(1) >= cnt) begin
          if (idx == '0 || e_len > best_len) begin
            hit <= idx; hit_off <= e_off; hit_len <= e_len; best_len <= e_len;
          end else begin
            hit <= best; hit_off <= best_off; hit_len <= best_len;
          end
        end else begin
          // first longest extent so far
          if (idx == '0 || e_len > best_len) begin
            best <= idx; best_len <= e_len; best_off <= e_off;
          end
          idx <= idx + EW'(1);
        end
      end
      eba_pkg::S_FIN: begin
        rsp.status <= status;
        rsp.extent_offset <= '0;
        rsp.extent_count <= '0;
        rsp.total_used <= volume_next;
        if (req.mode == eba_pkg::MODE_ALLOC && status == eba_pkg::ST_OK) begin
          rsp.extent_offset <= 24'(hit_off) + 24'(grp) * 24'(blocks_per_group);
          rsp.extent_count <= take_cnt;
        end
      end
      default: ;
    endcase
  end

  // checks
  `EBA_ASSERT_IMP(a_no_accept_clear, clearing, !in_ch.ready)
  `EBA_ASSERT_IMP(a_out_only_in_out, out_ch.valid, state == eba_pkg::S_OUT)
  `EBA_ASSERT_NEXT(a_fin_to_out, state == eba_pkg::S_FIN, out_ch.valid)

endmodule
